>>> src/bode_pkg.sv
// ----------------------------------------------------------------------------
// bode_pkg
// Shared types, codes and helpers for the bytea escape-format decoder.
// ----------------------------------------------------------------------------
package bode_pkg;

    // Character codes
    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_QUOTE  = 8'h27;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;

    // Default depth of the command queue between front and back end
    localparam int QUEUE_DEPTH_DEF = 4;

    // Most bytes one input item can produce
    localparam int MAX_RESULTS = 4;
    localparam int RES_IDX_W   = $clog2(MAX_RESULTS);

    // Input item
    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } in_item_t;

    // Result item
    typedef struct packed {
        logic [7:0] decoded_byte;
        logic       run_end;
        logic       string_end;
    } out_item_t;

    // Escape tracking phase
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,   // nothing held
        PH_BSL  = 2'd1,   // backslash held
        PH_DIG1 = 2'd2,   // backslash and one digit held
        PH_DIG2 = 2'd3    // backslash and two digits held
    } phase_t;

    // One queued command: the bytes of one input item, ready to emit
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [RES_IDX_W-1:0]        last_idx;  // index of the final byte
        logic                        fin;       // item closed the string
    } cmd_t;

    // Decimal digit check
    function automatic logic is_dec(input logic [7:0] c);
        is_dec = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    // Octal value of three decimal digits, read up to the first 8 or 9,
    // low 8 bits kept
    function automatic logic [7:0] octal_value(input logic [7:0] a,
                                               input logic [7:0] b,
                                               input logic [7:0] c);
        logic [3:0] ka;
        logic [3:0] kb;
        logic [3:0] kc;
        logic [8:0] v;
        ka = a[3:0];
        kb = b[3:0];
        kc = c[3:0];
        if (ka > 4'd7) begin
            v = 9'd0;
        end else if (kb > 4'd7) begin
            v = {6'd0, ka[2:0]};
        end else if (kc > 4'd7) begin
            v = {3'd0, ka[2:0], kb[2:0]};
        end else begin
            v = {ka[2:0], kb[2:0], kc[2:0]};
        end
        octal_value = v[7:0];
    endfunction

endpackage

>>> src/bode_front.sv
// ----------------------------------------------------------------------------
// bode_front
// Front end: tracks the escape phase and turns each accepted byte into a
// command holding the zero to four bytes it releases.
// ----------------------------------------------------------------------------
module bode_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              take,
    input  bode_pkg::in_item_t item,
    output logic              push,
    output bode_pkg::cmd_t    cmd
);
    import bode_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] held0_reg, held0_next;
    logic [7:0] held1_reg, held1_next;
    logic [2:0] count;
    logic [7:0] c;
    logic       fin;

    assign c   = item.text_byte;
    assign fin = item.final_byte;

    // Phase register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
        end else if (take) begin
            phase_reg <= phase_next;
        end
    end

    // Held digits
    always_ff @(posedge aclk) begin
        if (take) begin
            held0_reg <= held0_next;
            held1_reg <= held1_next;
        end
    end

    // Classify byte, build released bytes and next phase
    always_comb begin
        phase_next = phase_reg;
        held0_next = held0_reg;
        held1_next = held1_reg;
        cmd.bytes  = '0;
        count      = 3'd0;

        unique case (phase_reg)
            PH_IDLE: begin
                if (c == CHAR_BSLASH) begin
                    phase_next = PH_BSL;
                end else begin
                    cmd.bytes[0] = c;
                    count        = 3'd1;
                end
            end
            PH_BSL: begin
                if (c == CHAR_QUOTE || c == CHAR_BSLASH) begin
                    cmd.bytes[0] = c;
                    count        = 3'd1;
                    phase_next   = PH_IDLE;
                end else if (is_dec(c)) begin
                    held0_next = c;
                    phase_next = PH_DIG1;
                end else begin
                    cmd.bytes[0] = CHAR_BSLASH;
                    cmd.bytes[1] = c;
                    count        = 3'd2;
                    phase_next   = PH_IDLE;
                end
            end
            PH_DIG1: begin
                if (is_dec(c)) begin
                    held1_next = c;
                    phase_next = PH_DIG2;
                end else begin
                    cmd.bytes[0] = CHAR_BSLASH;
                    cmd.bytes[1] = held0_reg;
                    cmd.bytes[2] = c;
                    count        = 3'd3;
                    phase_next   = PH_IDLE;
                end
            end
            PH_DIG2: begin
                if (is_dec(c)) begin
                    cmd.bytes[0] = octal_value(held0_reg, held1_reg, c);
                    count        = 3'd1;
                end else begin
                    cmd.bytes[0] = CHAR_BSLASH;
                    cmd.bytes[1] = held0_reg;
                    cmd.bytes[2] = held1_reg;
                    cmd.bytes[3] = c;
                    count        = 3'd4;
                end
                phase_next = PH_IDLE;
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase

        // End of string inside an escape: release the held bytes.
        // An escape stays open only when nothing was released above.
        if (fin && phase_next != PH_IDLE) begin
            cmd.bytes[0] = CHAR_BSLASH;
            cmd.bytes[1] = held0_next;
            cmd.bytes[2] = held1_next;
            unique case (phase_next)
                PH_BSL:  count = 3'd1;
                PH_DIG1: count = 3'd2;
                default: count = 3'd3;
            endcase
            phase_next = PH_IDLE;
        end

        cmd.last_idx = RES_IDX_W'(count - 3'd1);
        cmd.fin      = fin;
    end

    assign push = take && (count != 3'd0);

endmodule

>>> src/bode_queue.sv
// ----------------------------------------------------------------------------
// bode_queue
// Small command FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module bode_queue #(
    parameter int DEPTH = bode_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  bode_pkg::cmd_t push_cmd,
    input  logic           pop,
    output bode_pkg::cmd_t head_cmd,
    output logic           empty,
    output logic           full
);
    import bode_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head_cmd = entry_reg[rd_ptr_reg];

endmodule

>>> src/bode_back.sv
// ----------------------------------------------------------------------------
// bode_back
// Back end: walks the bytes of the head command into the output register
// one per cycle while m_ready allows, tagging the run and string ends.
// ----------------------------------------------------------------------------
module bode_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_empty,
    input  bode_pkg::cmd_t      head_cmd,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output bode_pkg::out_item_t m_item
);
    import bode_pkg::*;

    logic [RES_IDX_W-1:0] idx_reg, idx_next;
    logic                 valid_reg, valid_next;
    out_item_t            item_reg, item_next;
    logic                 load;
    logic                 at_last;

    // Load the output register when it is empty or being drained
    assign load    = !q_empty && (!valid_reg || m_ready);
    assign at_last = (idx_reg == head_cmd.last_idx);
    assign pop     = load && at_last;

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        item_next  = item_reg;
        if (load) begin
            valid_next             = 1'b1;
            item_next.decoded_byte = head_cmd.bytes[idx_reg];
            item_next.run_end      = at_last;
            item_next.string_end   = at_last && head_cmd.fin;
            idx_next               = at_last ? '0 : idx_reg + 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

    assign m_valid = valid_reg;
    assign m_item  = item_reg;

endmodule

>>> src/bytea_octal_escape_decoder_unit.sv
// ----------------------------------------------------------------------------
// bytea_octal_escape_decoder_unit
// Decodes bytea escape-format text one byte at a time into raw bytes.
//
//   Channel  Direction  Handshake          Payload
//   s_       in         s_valid/s_ready    in_item_t  (text_byte, final_byte)
//   m_       out        m_valid/m_ready    out_item_t (decoded_byte, run_end,
//                                                      string_end)
//
// The front end classifies a byte in the cycle it is taken and queues the
// zero to four bytes it releases; s_ready drops only when the command queue
// is full. The back end emits one result per cycle while m_ready is high;
// single-byte items run back to back. Output is registered. Reset (aresetn
// low, synchronous) clears the escape phase, the queue and the output valid.
// ----------------------------------------------------------------------------
module bytea_octal_escape_decoder_unit #(
    parameter int QUEUE_DEPTH = bode_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bode_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output bode_pkg::out_item_t m_item
);
    import bode_pkg::*;

    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    logic take;
    cmd_t push_cmd;
    cmd_t head_cmd;

    // Input transfer
    assign s_ready = !q_full;
    assign take    = s_valid && s_ready;

    bode_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (take),
        .item    (s_item),
        .push    (push),
        .cmd     (push_cmd)
    );

    bode_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .empty    (q_empty),
        .full     (q_full)
    );

    bode_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .head_cmd (head_cmd),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the bytea escape-format decoder. A directed table covers
// plain bytes, quote and backslash escapes, octal escapes with overflow and
// stray 8/9 digits, broken escapes and end of string inside an escape. A
// random stream of mostly well-formed escapes follows. Every result transfer
// is checked field by field against a typed result or a cycle-free decode
// predictor, as the sender bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_top;
    import bode_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 355;
    localparam int DRAIN_CYCLES = 16;
    localparam int PRINT_CAP    = 100;

    // Directed row: input byte, final mark, and a typed-in single result
    typedef struct packed {
        logic [7:0] txt;
        logic       fin;
        logic       typed;
        logic [7:0] exp_data;
    } dir_row_t;

    localparam int DIR_ROWS = 27;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    // Decode predictor state
    phase_t     esc_phase  = PH_IDLE;
    logic [7:0] digit_hold [2];
    out_item_t  pred_buf [MAX_RESULTS];
    int         pred_n;

    // Decoded bytes still owed by the block, oldest first
    out_item_t  decoded_q [$];
    in_item_t   text_q [$];

    int cycle     = 0;
    int err_cnt   = 0;
    int burst_left = 4;
    int rcv_mode  = 0;
    int rcv_cnt   = 0;

    dir_row_t dir_table [DIR_ROWS] = '{
        '{8'h41,       1'b0, 1'b1, 8'h41},      // plain byte
        '{8'h00,       1'b0, 1'b1, 8'h00},      // zero byte passes through
        '{8'hFF,       1'b1, 1'b1, 8'hFF},      // top byte, closes string
        '{CHAR_BSLASH, 1'b0, 1'b0, 8'h00},
        '{CHAR_QUOTE,  1'b0, 1'b1, CHAR_QUOTE}, // escaped quote
        '{CHAR_BSLASH, 1'b0, 1'b0, 8'h00},
        '{CHAR_BSLASH, 1'b0, 1'b1, CHAR_BSLASH},// escaped backslash
        '{CHAR_BSLASH, 1'b0, 1'b0, 8'h00},
        '{8'h33,       1'b0, 1'b0, 8'h00},
        '{8'h37,       1'b0, 1'b0, 8'h00},
        '{8'h37,       1'b0, 1'b1, 8'hFF},      // \377
        '{CHAR_BSLASH, 1'b0, 1'b0, 8'h00},      // \765 overflows 8 bits
        '{8'h37,       1'b0, 1'b0, 8'h00},
        '{8'h36,       1'b0, 1'b0, 8'h00},
        '{8'h35,       1'b0, 1'b0, 8'h00},
        '{CHAR_BSLASH, 1'b0, 1'b0, 8'h00},      // \912: first digit not octal
        '{CHAR_NINE,   1'b0, 1'b0, 8'h00},
        '{8'h31,       1'b0, 1'b0, 8'h00},
        '{8'h32,       1'b0, 1'b0, 8'h00},
        '{CHAR_BSLASH, 1'b0, 1'b0, 8'h00},      // broken after backslash
        '{8'h5A,       1'b0, 1'b0, 8'h00},
        '{CHAR_BSLASH, 1'b0, 1'b0, 8'h00},      // broken by a backslash
        '{8'h31,       1'b0, 1'b0, 8'h00},
        '{8'h32,       1'b0, 1'b0, 8'h00},
        '{CHAR_BSLASH, 1'b0, 1'b0, 8'h00},
        '{CHAR_BSLASH, 1'b0, 1'b0, 8'h00},      // string ends inside escape
        '{8'h34,       1'b1, 1'b0, 8'h00}
    };

    bytea_octal_escape_decoder_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Cycle count and watchdog
    always @(posedge aclk) begin
        cycle++;
        if (cycle >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic is_digit(logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    // Octal value read up to the first 8 or 9, low 8 bits kept
    function automatic logic [7:0] octal_of(logic [7:0] a, logic [7:0] b,
                                            logic [7:0] c);
        logic [7:0]  d [3];
        int unsigned v;
        logic        stop;
        d[0] = a;
        d[1] = b;
        d[2] = c;
        v    = 0;
        stop = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (!stop) begin
                if (d[i] - CHAR_ZERO > 8'd7) stop = 1'b1;
                else v = v * 8 + (d[i] - CHAR_ZERO);
            end
        end
        return v[7:0];
    endfunction

    function automatic void add_out(logic [7:0] b);
        pred_buf[pred_n] = '{decoded_byte: b, run_end: 1'b0, string_end: 1'b0};
        pred_n++;
    endfunction

    // Decode one text byte into pred_buf; returns the number of bytes released
    function automatic int predict_decode(in_item_t it);
        logic [7:0] c;
        c      = it.text_byte;
        pred_n = 0;
        case (esc_phase)
            PH_IDLE: begin
                if (c == CHAR_BSLASH) esc_phase = PH_BSL;
                else add_out(c);
            end
            PH_BSL: begin
                if (c == CHAR_QUOTE || c == CHAR_BSLASH) begin
                    add_out(c);
                    esc_phase = PH_IDLE;
                end else if (is_digit(c)) begin
                    digit_hold[0] = c;
                    esc_phase = PH_DIG1;
                end else begin
                    add_out(CHAR_BSLASH);
                    add_out(c);
                    esc_phase = PH_IDLE;
                end
            end
            PH_DIG1: begin
                if (is_digit(c)) begin
                    digit_hold[1] = c;
                    esc_phase = PH_DIG2;
                end else begin
                    add_out(CHAR_BSLASH);
                    add_out(digit_hold[0]);
                    add_out(c);
                    esc_phase = PH_IDLE;
                end
            end
            default: begin
                if (is_digit(c)) begin
                    add_out(octal_of(digit_hold[0], digit_hold[1], c));
                end else begin
                    add_out(CHAR_BSLASH);
                    add_out(digit_hold[0]);
                    add_out(digit_hold[1]);
                    add_out(c);
                end
                esc_phase = PH_IDLE;
            end
        endcase
        // end of string flushes whatever escape is still held
        if (it.final_byte && esc_phase != PH_IDLE) begin
            add_out(CHAR_BSLASH);
            if (esc_phase >= PH_DIG1) add_out(digit_hold[0]);
            if (esc_phase >= PH_DIG2) add_out(digit_hold[1]);
            esc_phase = PH_IDLE;
        end
        if (pred_n > 0) begin
            pred_buf[pred_n-1].run_end    = 1'b1;
            pred_buf[pred_n-1].string_end = it.final_byte;
        end
        return pred_n;
    endfunction

    task automatic report_mismatch(string msg);
        if (err_cnt < PRINT_CAP) $display("tb: mismatch at cycle %0d: %s", cycle, msg);
        err_cnt++;
    endtask

    task automatic check_result(out_item_t got);
        out_item_t want;
        if (decoded_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result byte %02h", got.decoded_byte));
        end else begin
            want = decoded_q.pop_front();
            if (got.decoded_byte !== want.decoded_byte)
                report_mismatch($sformatf("decoded_byte %02h, want %02h",
                                          got.decoded_byte, want.decoded_byte));
            if (got.run_end !== want.run_end)
                report_mismatch($sformatf("run_end %b, want %b",
                                          got.run_end, want.run_end));
            if (got.string_end !== want.string_end)
                report_mismatch($sformatf("string_end %b, want %b",
                                          got.string_end, want.string_end));
        end
    endtask

    // Receiver: stall behavior switches between modes picked at random
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) check_result(m_item);
        rcv_cnt++;
        if (rcv_cnt == 48) begin
            rcv_cnt  = 0;
            rcv_mode = $urandom_range(0, 3);
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            case (rcv_mode)
                0:       m_ready <= 1'b1;
                1:       m_ready <= ($urandom_range(0, 3) != 0);
                2:       m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= rcv_cnt[0];
            endcase
        end
    end

    // Drive one text byte, wait for its transfer, then log what it releases
    task automatic send_text(in_item_t it, logic typed, logic [7:0] exp_data);
        int n;
        int gap;
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n = predict_decode(it);
        if (typed) begin
            decoded_q.push_back('{decoded_byte: exp_data, run_end: 1'b1,
                                  string_end: it.final_byte});
        end else begin
            for (int k = 0; k < n; k++) decoded_q.push_back(pred_buf[k]);
        end
        // burst bookkeeping: long bursts now and then, short ones otherwise
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic push_text(logic [7:0] b);
        text_q.push_back('{text_byte: b, final_byte: ($urandom_range(0, 15) == 0)});
    endtask

    // Random text: mostly well-formed escapes with random content, some noise
    task automatic build_random_text();
        int r;
        while (text_q.size() < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                push_text(($urandom_range(0, 255) == CHAR_BSLASH) ? 8'h41
                                                                 : 8'($urandom_range(0, 255)));
            end else if (r < 50) begin
                push_text(CHAR_BSLASH);
                repeat (3) push_text(CHAR_ZERO + 8'($urandom_range(0, 9)));
            end else if (r < 58) begin
                push_text(CHAR_BSLASH);
                push_text(CHAR_QUOTE);
            end else if (r < 66) begin
                push_text(CHAR_BSLASH);
                push_text(CHAR_BSLASH);
            end else if (r < 76) begin
                push_text(CHAR_BSLASH);
                push_text(8'($urandom_range(0, 255)));
            end else if (r < 84) begin
                push_text(CHAR_BSLASH);
                push_text(CHAR_ZERO + 8'($urandom_range(0, 9)));
                push_text(8'($urandom_range(0, 255)));
            end else if (r < 92) begin
                push_text(CHAR_BSLASH);
                repeat (2) push_text(CHAR_ZERO + 8'($urandom_range(0, 9)));
                push_text(8'($urandom_range(0, 255)));
            end else begin
                push_text(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Main sequence
    initial begin
        in_item_t it;
        int       idx;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        for (int i = 0; i < DIR_ROWS; i++) begin
            it = '{text_byte: dir_table[i].txt, final_byte: dir_table[i].fin};
            send_text(it, dir_table[i].typed, dir_table[i].exp_data);
        end

        // random stream, with one full drain partway through
        build_random_text();
        idx = 0;
        while (text_q.size() > 0) begin
            if (idx == RANDOM_ITEMS / 2) begin
                s_valid <= 1'b0;
                @(posedge aclk);
                while (decoded_q.size() != 0) @(posedge aclk);
            end
            send_text(text_q.pop_front(), 1'b0, 8'h00);
            idx++;
        end
        s_valid <= 1'b0;

        // wait for the owed bytes, then watch for strays
        while (decoded_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_cnt == 0 && decoded_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
